@@ sv/assert_macros.svh @@
// Assertion helpers shared by upe_front and upe_queue.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/upe_pkg.sv @@
package upe_pkg;

  // Link header lengths and IPv4/UDP constants
  localparam logic [4:0]  LINK_LEN_ETH = 5'd14;
  localparam logic [4:0]  LINK_LEN_SLL = 5'd16;
  localparam logic [15:0] TYPE_IPV4    = 16'h0800;
  localparam logic [3:0]  IP_VERSION   = 4'd4;
  localparam logic [15:0] FRAG_MASK    = 16'h1fff;
  localparam logic [15:0] MORE_FRAGS   = 16'h2000;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [15:0] IP_MIN       = 16'd20;
  localparam logic [15:0] UDP_MIN      = 16'd8;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_FRAME_SHORT = 4'd1,
    ST_IP_SHORT    = 4'd2,
    ST_ETHERTYPE   = 4'd3,
    ST_VERSION     = 4'd4,
    ST_FRAGMENT    = 4'd5,
    ST_NOT_UDP     = 4'd6,
    ST_IHL         = 4'd7,
    ST_IP_LEN      = 4'd8,
    ST_UDP_SHORT   = 4'd9,
    ST_UDP_LEN     = 4'd10
  } status_t;

  // One result beat as it travels from front to back
  typedef struct packed {
    logic       data_valid;
    logic [7:0] payload_byte;
    logic       frame_done;
    status_t    status;
  } res_t;

endpackage

@@ sv/upe_if.sv @@
interface upe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;
  modport source (output valid, output frame_byte, output end_of_frame, input ready);
  modport sink (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

interface upe_out_if;
  logic       valid;
  logic       ready;
  logic       data_valid;
  logic [7:0] payload_byte;
  logic       frame_done;
  logic [3:0] status;
  modport source (output valid, output data_valid, output payload_byte,
                  output frame_done, output status, input ready);
  modport sink (input valid, input data_valid, input payload_byte,
                input frame_done, input status, output ready);
endinterface

interface upe_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/upe_front.sv @@
`include "assert_macros.svh"

module upe_front
  import upe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  upe_in_if.sink    in_ch,
  upe_cfg_if.sink   cfg_ch,
  input  logic      q_ready,
  output logic      push,
  output res_t      push_res
);

  // Checks that need no frame size, first failing one wins
  function automatic status_t header_status(input logic [15:0] tw,
                                            input logic [7:0]  vi,
                                            input logic [15:0] tot,
                                            input logic [15:0] ff,
                                            input logic [7:0]  proto,
                                            input logic [15:0] udp);
    logic [15:0] h;
    logic [15:0] room;
    status_t     st;
    h    = {10'd0, vi[3:0], 2'b00};
    room = tot - h;
    if (tw != TYPE_IPV4)                    st = ST_ETHERTYPE;
    else if (vi[7:4] != IP_VERSION)         st = ST_VERSION;
    else if ((ff & (MORE_FRAGS | FRAG_MASK)) != 16'd0) st = ST_FRAGMENT;
    else if (proto != PROTO_UDP)            st = ST_NOT_UDP;
    else if (h < IP_MIN)                    st = ST_IHL;
    else if (tot < h)                       st = ST_IP_LEN;
    else if (room < UDP_MIN)                st = ST_UDP_SHORT;
    else if (udp < UDP_MIN || udp > room)   st = ST_UDP_LEN;
    else                                    st = ST_OK;
    return st;
  endfunction

  logic        link_type_r;
  logic [16:0] pos_r, pos_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [15:0] type_r, type_nxt;
  logic [7:0]  vi_r, vi_nxt;
  logic [15:0] tot_r, tot_nxt;
  logic [15:0] ff_r, ff_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [15:0] udp_r, udp_nxt;

  logic        accept;
  logic        last;
  logic [7:0]  b;
  logic [4:0]  link_len;
  logic [16:0] link_len17;
  logic        in_ip;
  logic [16:0] rel;
  logic [16:0] h17;
  logic [15:0] word;
  logic        fwd;
  status_t     hs_cur;
  status_t     hs_fin;
  status_t     st_fin;
  logic [17:0] size;
  logic [17:0] ip_size;
  logic [17:0] h_fin18;
  logic [17:0] tot_fin18;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = q_ready;
  assign accept       = in_ch.valid && q_ready;
  assign last         = in_ch.end_of_frame;
  assign b            = in_ch.frame_byte;

  // Position within the link and IP headers
  assign link_len   = link_type_r ? LINK_LEN_SLL : LINK_LEN_ETH;
  assign link_len17 = {12'd0, link_len};
  assign in_ip      = pos_r >= link_len17;
  assign rel        = pos_r - link_len17;
  assign h17        = {11'd0, vi_r[3:0], 2'b00};
  assign word       = {held_r, b};

  // Header fields stay put on any byte that can forward, so the held fields decide
  assign hs_cur = header_status(type_r, vi_r, tot_r, ff_r, proto_r, udp_r);
  assign fwd    = in_ip && (rel != 17'd0) && (rel >= h17 + 17'd8) &&
                  (rel < h17 + {1'b0, udp_r}) && (hs_cur == ST_OK);

  // Capture header fields as they pass
  always_comb begin
    type_nxt  = type_r;
    vi_nxt    = vi_r;
    tot_nxt   = tot_r;
    ff_nxt    = ff_r;
    proto_nxt = proto_r;
    udp_nxt   = udp_r;
    if (pos_r == link_len17 - 17'd1) begin
      type_nxt = word;
    end
    if (in_ip) begin
      if (rel == 17'd0)      vi_nxt    = b;
      else if (rel == 17'd3) tot_nxt   = word;
      else if (rel == 17'd7) ff_nxt    = word;
      else if (rel == 17'd9) proto_nxt = b;
      if (rel != 17'd0 && rel == h17 + 17'd5) begin
        udp_nxt = word;
      end
    end
  end

  // Final status from the fields as they stand after this byte
  assign size      = {1'b0, pos_r} + 18'd1;
  assign ip_size   = size - {13'd0, link_len};
  assign h_fin18   = {12'd0, vi_nxt[3:0], 2'b00};
  assign tot_fin18 = {2'd0, tot_nxt};
  assign hs_fin    = header_status(type_nxt, vi_nxt, tot_nxt, ff_nxt, proto_nxt, udp_nxt);

  always_comb begin
    if (size < {13'd0, link_len})                        st_fin = ST_FRAME_SHORT;
    else if (ip_size < 18'd20)                           st_fin = ST_IP_SHORT;
    else if (hs_fin != ST_OK && hs_fin < ST_IP_LEN)      st_fin = hs_fin;
    else if (tot_fin18 > ip_size || tot_fin18 < h_fin18) st_fin = ST_IP_LEN;
    else                                                 st_fin = hs_fin;
  end

  // Build the result beat for payload and final bytes
  assign push                  = accept && (fwd || last);
  assign push_res.data_valid   = fwd;
  assign push_res.payload_byte = fwd ? b : 8'd0;
  assign push_res.frame_done   = last;
  assign push_res.status       = last ? st_fin : ST_OK;

  // Advance position, clear per-frame state on the final byte
  always_comb begin
    pos_nxt  = pos_r;
    held_nxt = held_r;
    if (accept) begin
      held_nxt = b;
      if (last) begin
        pos_nxt  = 17'd0;
        held_nxt = 8'd0;
      end else if (pos_r != {17{1'b1}}) begin
        pos_nxt = pos_r + 17'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_type_r <= 1'b0;
      pos_r       <= '0;
      held_r      <= '0;
      type_r      <= '0;
      vi_r        <= '0;
      tot_r       <= '0;
      ff_r        <= '0;
      proto_r     <= '0;
      udp_r       <= '0;
    end else begin
      if (cfg_ch.valid) begin
        link_type_r <= cfg_ch.data;
      end
      pos_r  <= pos_nxt;
      held_r <= held_nxt;
      if (accept && last) begin
        type_r  <= '0;
        vi_r    <= '0;
        tot_r   <= '0;
        ff_r    <= '0;
        proto_r <= '0;
        udp_r   <= '0;
      end else if (accept) begin
        type_r  <= type_nxt;
        vi_r    <= vi_nxt;
        tot_r   <= tot_nxt;
        ff_r    <= ff_nxt;
        proto_r <= proto_nxt;
        udp_r   <= udp_nxt;
      end
    end
  end

  `ASSERT_NEXT(a_frame_restart, accept && last, pos_r == 17'd0 && vi_r == 8'd0,
               "per-frame state not cleared after final byte")
  `ASSERT_IMPL(a_fwd_past_headers, fwd, pos_r >= link_len17 + 17'd28,
               "payload forwarded inside the headers")

endmodule

@@ sv/upe_queue.sv @@
`include "assert_macros.svh"

module upe_queue
  import upe_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_res,
  output logic q_ready,
  input  logic pop,
  output logic q_valid,
  output res_t q_head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL      = CW'(DEPTH);

  res_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign q_ready = count_r != FULL;
  assign q_valid = count_r != '0;
  assign q_head  = mem_r[rd_ptr_r];
  assign do_push = push && q_ready;
  assign do_pop  = pop && q_valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_res;
    end
  end

  `ASSERT_IMPL(a_no_overflow, push, q_ready, "beat pushed into a full queue")
  `ASSERT_NEXT(a_drain_to_empty, count_r == CW'(1) && do_pop && !do_push, !q_valid,
               "queue not empty after last beat popped")

endmodule

@@ sv/upe_back.sv @@
module upe_back
  import upe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  res_t      q_head,
  output logic      pop,
  upe_out_if.source out_ch
);

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  // Load the output register whenever it is empty or being drained
  assign pop = q_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res_r <= q_head;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.data_valid   = out_res_r.data_valid;
  assign out_ch.payload_byte = out_res_r.payload_byte;
  assign out_ch.frame_done   = out_res_r.frame_done;
  assign out_ch.status       = out_res_r.status;

endmodule

@@ sv/udp_payload_extractor_top.sv @@
// UDP payload extractor for captured frames.
// in_ch takes one frame byte per beat, end_of_frame set on the final byte.
// cfg_ch writes link_type (0 Ethernet, 14-byte header; 1 Linux cooked, 16 bytes);
// write it between frames, it is always ready.
// out_ch gives one beat for every UDP payload byte (data_valid set) and one
// for every final byte (frame_done set, status holds the frame's result code).
// Payload is forwarded before the frame size is known: drop it when the
// final status is not zero.
// Throughput: one byte per cycle while the queue is not full; the front classifies
// a byte in the cycle it is accepted. A result reaches out_ch through a queue
// write, then an output register load.
// When out_ch stalls, results collect in the queue and the output register;
// in_ch.ready drops only when the queue is full.
// Reset (rst_n low, synchronous) empties the queue and output register,
// clears frame state and sets link_type to Ethernet. No clearing pass.
module udp_payload_extractor_top
  import upe_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  upe_in_if.sink    in_ch,
  upe_cfg_if.sink   cfg_ch,
  upe_out_if.source out_ch
);

  logic push;
  res_t push_res;
  logic q_ready;
  logic pop;
  logic q_valid;
  res_t q_head;

  upe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .q_ready  (q_ready),
    .push     (push),
    .push_res (push_res)
  );

  upe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_res (push_res),
    .q_ready  (q_ready),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_head   (q_head)
  );

  upe_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import upe_pkg::*;

  localparam int UNTYPED = -1;

  // One frame to send: header fields, payload length, forced size, link flip
  typedef struct {
    bit          link;
    logic [15:0] etype;
    logic [7:0]  vihl;
    logic [15:0] tot;
    logic [15:0] frag;
    logic [7:0]  proto;
    logic [15:0] ulen;
    int          paylen;
    int          size;     // -1: natural size
    int          swap_at;  // byte index where link type flips, -1: none
    int          st;       // status read off by hand, UNTYPED: predicted
  } frame_desc_t;

  logic clk;
  logic rst_n;

  upe_in_if  in_ch ();
  upe_cfg_if cfg_ch ();
  upe_out_if out_ch ();

  udp_payload_extractor_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  // Predictor state, at the block's widths
  bit          link_sel   = 1'b0;
  logic [16:0] pos        = '0;
  logic [7:0]  prev_byte  = '0;
  logic [15:0] eth_type   = '0;
  logic [7:0]  ver_ihl    = '0;
  logic [15:0] ip_len     = '0;
  logic [15:0] frag_word  = '0;
  logic [7:0]  ip_proto   = '0;
  logic [15:0] udp_len    = '0;

  res_t udp_beats_due[$];
  int   fixed_status_q[$];
  int   bad_beats  = 0;
  int   sent_bytes = 0;
  bit   cur_link   = 1'b0;
  bit   quiet      = 1'b0;

  frame_desc_t dir_tbl [24] = '{
    '{1'b0, TYPE_IPV4, 8'h45, 16'd32, 16'h0000, PROTO_UDP, 16'd12, 4, -1, -1, ST_OK},
    '{1'b1, TYPE_IPV4, 8'h45, 16'd33, 16'h0000, PROTO_UDP, 16'd13, 5, -1, -1, ST_OK},
    '{1'b0, TYPE_IPV4, 8'h45, 16'd28, 16'h0000, PROTO_UDP, 16'd8, 0, -1, -1, ST_OK},
    '{1'b1, TYPE_IPV4, 8'h45, 16'd28, 16'h0000, PROTO_UDP, 16'd8, 0, 1, -1,
      ST_FRAME_SHORT},
    '{1'b0, TYPE_IPV4, 8'h45, 16'd28, 16'h0000, PROTO_UDP, 16'd8, 0, 13, -1,
      ST_FRAME_SHORT},
    '{1'b0, TYPE_IPV4, 8'h45, 16'd28, 16'h0000, PROTO_UDP, 16'd8, 0, 33, -1, ST_IP_SHORT},
    '{1'b1, TYPE_IPV4, 8'h45, 16'd28, 16'h0000, PROTO_UDP, 16'd8, 0, 35, -1, ST_IP_SHORT},
    '{1'b0, 16'h86DD, 8'h45, 16'd32, 16'h0000, PROTO_UDP, 16'd12, 4, -1, -1, ST_ETHERTYPE},
    '{1'b1, 16'hFFFF, 8'h45, 16'd32, 16'h0000, PROTO_UDP, 16'd12, 4, -1, -1, ST_ETHERTYPE},
    '{1'b0, TYPE_IPV4, 8'h65, 16'd32, 16'h0000, PROTO_UDP, 16'd12, 4, -1, -1, ST_VERSION},
    '{1'b0, TYPE_IPV4, 8'h45, 16'd32, 16'h2000, PROTO_UDP, 16'd12, 4, -1, -1, ST_FRAGMENT},
    '{1'b0, TYPE_IPV4, 8'h45, 16'd32, 16'h1FFF, PROTO_UDP, 16'd12, 4, -1, -1, ST_FRAGMENT},
    '{1'b0, TYPE_IPV4, 8'h45, 16'd31, 16'h4000, PROTO_UDP, 16'd11, 3, -1, -1, ST_OK},
    '{1'b0, TYPE_IPV4, 8'h45, 16'd32, 16'h0000, 8'd6, 16'd12, 4, -1, -1, ST_NOT_UDP},
    '{1'b0, TYPE_IPV4, 8'h44, 16'd32, 16'h0000, PROTO_UDP, 16'd12, 4, -1, -1, ST_IHL},
    '{1'b1, TYPE_IPV4, 8'h4F, 16'd71, 16'h0000, PROTO_UDP, 16'd11, 3, -1, -1, UNTYPED},
    '{1'b0, TYPE_IPV4, 8'h45, 16'd100, 16'h0000, PROTO_UDP, 16'd12, 4, -1, -1, ST_IP_LEN},
    '{1'b0, TYPE_IPV4, 8'h45, 16'd10, 16'h0000, PROTO_UDP, 16'd12, 4, -1, -1, ST_IP_LEN},
    '{1'b0, TYPE_IPV4, 8'h45, 16'd25, 16'h0000, PROTO_UDP, 16'd8, 0, -1, -1, ST_UDP_SHORT},
    '{1'b0, TYPE_IPV4, 8'h45, 16'd28, 16'h0000, PROTO_UDP, 16'd4, 0, -1, -1, ST_UDP_LEN},
    '{1'b0, TYPE_IPV4, 8'h45, 16'd32, 16'h0000, PROTO_UDP, 16'd200, 4, -1, -1, ST_UDP_LEN},
    '{1'b0, TYPE_IPV4, 8'h45, 16'hFFFF, 16'h0000, PROTO_UDP, 16'hFFFF, 2, -1, -1,
      ST_IP_LEN},
    '{1'b0, TYPE_IPV4, 8'h45, 16'd34, 16'h0000, PROTO_UDP, 16'd10, 6, 60, -1, UNTYPED},
    '{1'b0, TYPE_IPV4, 8'h45, 16'd32, 16'h0000, PROTO_UDP, 16'd12, 4, -1, 5, UNTYPED}
  };

  // Header checks that need no frame size
  function automatic status_t header_verdict();
    int unsigned h, tl, ul;
    h  = 4 * ver_ihl[3:0];
    tl = ip_len;
    ul = udp_len;
    if (eth_type != TYPE_IPV4) return ST_ETHERTYPE;
    if (ver_ihl[7:4] != IP_VERSION) return ST_VERSION;
    if ((frag_word & (MORE_FRAGS | FRAG_MASK)) != 0) return ST_FRAGMENT;
    if (ip_proto != PROTO_UDP) return ST_NOT_UDP;
    if (h < IP_MIN) return ST_IHL;
    if (tl < h) return ST_IP_LEN;
    if (tl - h < UDP_MIN) return ST_UDP_SHORT;
    if (ul < UDP_MIN || ul > tl - h) return ST_UDP_LEN;
    return ST_OK;
  endfunction

  // Status on the final byte, size checks first
  function automatic status_t frame_verdict(input int unsigned llen);
    int unsigned fsize, ipsz;
    status_t     st;
    fsize = pos + 1;
    if (fsize < llen) return ST_FRAME_SHORT;
    ipsz = fsize - llen;
    if (ipsz < IP_MIN) return ST_IP_SHORT;
    st = header_verdict();
    if (st != ST_OK && st < ST_IP_LEN) return st;
    if (ip_len > ipsz) return ST_IP_LEN;
    return st;
  endfunction

  // Advance the extractor by one byte; returns 1 when a beat is due
  function automatic bit udp_extract_step(input logic [7:0] b, input logic eof,
                                          output res_t r);
    int unsigned llen, p, rel, h;
    bit          fwd;
    llen = link_sel ? LINK_LEN_SLL : LINK_LEN_ETH;
    p    = pos;
    fwd  = 1'b0;
    r    = '0;
    if (p == llen - 1) eth_type = {prev_byte, b};
    if (p >= llen) begin
      rel = p - llen;
      h   = 4 * ver_ihl[3:0];
      if (rel == 0) ver_ihl = b;
      else if (rel == 3) ip_len = {prev_byte, b};
      else if (rel == 7) frag_word = {prev_byte, b};
      else if (rel == 9) ip_proto = b;
      if (rel > 0 && rel == h + 5) udp_len = {prev_byte, b};
      if (rel > 0 && rel >= h + UDP_MIN && rel < h + udp_len && header_verdict() == ST_OK)
        fwd = 1'b1;
    end
    prev_byte = b;
    if (eof) begin
      r.data_valid   = fwd;
      r.payload_byte = fwd ? b : 8'h00;
      r.frame_done   = 1'b1;
      r.status       = frame_verdict(llen);
      // clear per-frame state
      pos       = '0;
      prev_byte = '0;
      eth_type  = '0;
      ver_ihl   = '0;
      ip_len    = '0;
      frag_word = '0;
      ip_proto  = '0;
      udp_len   = '0;
      return 1'b1;
    end
    if (pos != 17'h1FFFF) pos = pos + 1'b1;
    if (fwd) begin
      r.data_valid   = 1'b1;
      r.payload_byte = b;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // IP header bytes laid out in a built frame
  function automatic int hdr_span(input logic [7:0] vihl);
    return (vihl[3:0] > 5) ? 4 * vihl[3:0] : 20;
  endfunction

  // Random frame: mostly well formed, some with one bad field, some noise
  function automatic frame_desc_t rand_frame();
    frame_desc_t d;
    int          kind, nsize;
    d.link    = ($urandom_range(0, 4) == 0) ? !cur_link : cur_link;
    d.etype   = TYPE_IPV4;
    d.vihl    = ($urandom_range(0, 3) == 0) ? {IP_VERSION, 4'($urandom_range(5, 15))} : 8'h45;
    d.frag    = $urandom_range(0, 1) ? 16'h4000 : 16'h0000;
    d.proto   = PROTO_UDP;
    d.paylen  = $urandom_range(0, 20);
    d.ulen    = 16'(8 + d.paylen);
    d.tot     = 16'(4 * d.vihl[3:0] + 8 + d.paylen);
    d.size    = -1;
    d.swap_at = -1;
    d.st      = UNTYPED;
    nsize = (d.link ? 16 : 14) + hdr_span(d.vihl) + 8 + d.paylen;
    kind  = $urandom_range(0, 99);
    if (kind < 60) begin
      if ($urandom_range(0, 3) == 0) d.size = nsize + $urandom_range(1, 10);
    end else if (kind < 88) begin
      case ($urandom_range(0, 7))
        0: d.etype = 16'($urandom);
        1: d.vihl[7:4] = 4'($urandom);
        2: d.frag = 16'($urandom);
        3: d.proto = 8'($urandom);
        4: d.vihl[3:0] = 4'($urandom_range(0, 4));
        5: d.tot = 16'($urandom_range(0, 80));
        6: d.ulen = 16'($urandom_range(0, 40));
        default: d.size = $urandom_range(1, nsize - 1);
      endcase
    end else begin
      d.etype = 16'($urandom);
      d.vihl  = 8'($urandom);
      d.tot   = 16'($urandom);
      d.frag  = 16'($urandom);
      d.proto = 8'($urandom);
      d.ulen  = 16'($urandom);
      d.size  = $urandom_range(1, 90);
    end
    return d;
  endfunction

  // Write link_type once the block has drained
  task automatic set_link(input bit v);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (udp_beats_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_link = v;
  endtask

  // Offer one byte, with random idle cycles ahead of it outside quiet stretches
  task automatic put_byte(input logic [7:0] b, input logic eof);
    while (!quiet && $urandom_range(0, 99) < 36) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.frame_byte   <= b;
    in_ch.end_of_frame <= eof;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Lay out a frame byte by byte and send it
  task automatic send_frame(input frame_desc_t d);
    logic [7:0] fb[$];
    bit         lk;
    lk = (d.swap_at >= 0) ? !d.link : d.link;
    repeat ((lk ? 16 : 14) - 2) fb.push_back(8'($urandom));
    fb.push_back(d.etype[15:8]);
    fb.push_back(d.etype[7:0]);
    fb.push_back(d.vihl);
    fb.push_back(8'($urandom));
    fb.push_back(d.tot[15:8]);
    fb.push_back(d.tot[7:0]);
    repeat (2) fb.push_back(8'($urandom));
    fb.push_back(d.frag[15:8]);
    fb.push_back(d.frag[7:0]);
    fb.push_back(8'($urandom));
    fb.push_back(d.proto);
    repeat (hdr_span(d.vihl) - 10) fb.push_back(8'($urandom));
    repeat (4) fb.push_back(8'($urandom));
    fb.push_back(d.ulen[15:8]);
    fb.push_back(d.ulen[7:0]);
    repeat (2 + d.paylen) fb.push_back(8'($urandom));
    if (d.size >= 0) begin
      while (fb.size() > d.size) void'(fb.pop_back());
      while (fb.size() < d.size) fb.push_back(8'($urandom));
    end
    if (d.link != cur_link) set_link(d.link);
    fixed_status_q.push_back(d.st);
    foreach (fb[i]) begin
      if (i == d.swap_at) set_link(!d.link);
      put_byte(fb[i], i == fb.size() - 1);
    end
    sent_bytes += fb.size();
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stall the result side at random, except in quiet stretches
  always @(posedge clk) out_ch.ready <= quiet || ($urandom_range(0, 99) >= 36);

  // Predict on every accepted byte, check every accepted beat
  always @(posedge clk) begin : watch
    res_t got, want;
    int   fixed_st;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) link_sel = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        if (udp_extract_step(in_ch.frame_byte, in_ch.end_of_frame, want)) begin
          if (want.frame_done) begin
            fixed_st = fixed_status_q.pop_front();
            if (fixed_st != UNTYPED) want.status = status_t'(fixed_st);
          end
          udp_beats_due.push_back(want);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got.data_valid   = out_ch.data_valid;
        got.payload_byte = out_ch.payload_byte;
        got.frame_done   = out_ch.frame_done;
        got.status       = status_t'(out_ch.status);
        if (udp_beats_due.size() == 0) begin
          if (bad_beats < 10)
            $display("unexpected beat: dv=%0b byte=%02h done=%0b st=%0d",
                     got.data_valid, got.payload_byte, got.frame_done, got.status);
          bad_beats++;
        end else begin
          want = udp_beats_due.pop_front();
          if (got.data_valid !== want.data_valid || got.payload_byte !== want.payload_byte ||
              got.frame_done !== want.frame_done || got.status !== want.status) begin
            if (bad_beats < 10)
              $display("beat mismatch: exp dv=%0b byte=%02h done=%0b st=%0d",
                       want.data_valid, want.payload_byte, want.frame_done, want.status,
                       ", got dv=%0b byte=%02h done=%0b st=%0d",
                       got.data_valid, got.payload_byte, got.frame_done, got.status);
            bad_beats++;
          end
        end
      end
    end
  end

  initial begin
    int nr;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.frame_byte   <= 8'h00;
    in_ch.end_of_frame <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.data        <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames
    quiet = 1'b0;
    foreach (dir_tbl[i]) begin
      send_frame(dir_tbl[i]);
    end

    // random frames, with a quiet stretch in the middle
    sent_bytes = 0;
    nr = 0;
    while (sent_bytes < 550) begin
      quiet = (nr >= 3 && nr < 8);
      send_frame(rand_frame());
      nr++;
    end
    quiet = 1'b0;

    // drain and finish
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (udp_beats_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (bad_beats == 0 && udp_beats_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/upe_pkg.sv
sv/upe_if.sv
sv/upe_front.sv
sv/upe_queue.sv
sv/upe_back.sv
sv/udp_payload_extractor_top.sv
test/tb.sv
